### sv/lcd_window_fill_streamer_core_macros.svh
// Assertion macros shared by the window fill streamer RTL.
`ifndef LCD_WINDOW_FILL_STREAMER_CORE_MACROS_SVH
`define LCD_WINDOW_FILL_STREAMER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LWF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lwf: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LWF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lwf: next-cycle check failed");

`endif

### sv/lwf_pkg.sv
// Types, constants and helper functions of the window fill streamer.
package lwf_pkg;

    localparam int MaxPanelSide = 1024;
    localparam int SideW        = $clog2(MaxPanelSide + 1);
    localparam int CfgW         = 11;
    localparam int CoordW       = 16;
    localparam int ColorW       = 24;
    localparam int RunW         = 21;
    localparam int AddrW        = 4;
    localparam int DataW        = 32;
    localparam int QDepth       = 4;
    localparam int QPtrW        = $clog2(QDepth);
    localparam int QCntW        = $clog2(QDepth + 1);

    localparam logic [RunW-1:0] RunMax = '1;

    localparam logic [CfgW-1:0] ResetPanelWidth  = 11'd128;
    localparam logic [CfgW-1:0] ResetPanelHeight = 11'd160;
    localparam logic            ResetPixelFormat = 1'b0;

    localparam logic [1:0] RegPanelWidth  = 2'd0;
    localparam logic [1:0] RegPanelHeight = 2'd1;
    localparam logic [1:0] RegPixelFormat = 2'd2;

    localparam logic [7:0] CmdColumnSet = 8'h2A;
    localparam logic [7:0] CmdRowSet    = 8'h2B;
    localparam logic [7:0] CmdRamWrite  = 8'h2C;

    localparam logic [7:0] Mask666 = 8'hFC;
    localparam logic       Format666 = 1'b1;

    typedef enum logic [1:0] {
        OP_SET_COLOR = 2'd0,
        OP_PIXEL     = 2'd1,
        OP_FILL      = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_CS_LOW  = 3'd0,
        KIND_CMD     = 3'd1,
        KIND_DATA    = 3'd2,
        KIND_RUN     = 3'd3,
        KIND_CS_HIGH = 3'd4
    } kind_t;

    typedef struct packed {
        logic [CfgW-1:0] panel_width;
        logic [CfgW-1:0] panel_height;
        logic            pixel_format;
    } cfg_t;

    // One clamped draw window, ready for the byte sequencer.
    typedef struct packed {
        logic [SideW-1:0]  x_lo;
        logic [SideW-1:0]  x_hi;
        logic [SideW-1:0]  y_lo;
        logic [SideW-1:0]  y_hi;
        logic [ColorW-1:0] pattern;
        logic [RunW-1:0]   run;
    } draw_cmd_t;

    // A zero side reads as one, anything past the largest panel as the largest.
    function automatic logic [SideW-1:0] eff_side(input logic [CfgW-1:0] v);
        if (v == '0) begin
            return SideW'(1);
        end else if (int'(v) > MaxPanelSide) begin
            return SideW'(MaxPanelSide);
        end
        return SideW'(v);
    endfunction

    function automatic logic [SideW-1:0] clamp_coord(input logic signed [CoordW-1:0] v,
                                                     input logic [SideW-1:0] side);
        logic [SideW-1:0] hi;
        hi = side - 1'b1;
        if (v[CoordW-1]) begin
            return '0;
        end else if ({1'b0, v[CoordW-2:0]} > CoordW'(hi)) begin
            return hi;
        end
        return SideW'(v[CoordW-2:0]);
    endfunction

    function automatic logic [ColorW-1:0] pack_pixel(input logic [ColorW-1:0] color,
                                                     input logic fmt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = color[23:16];
        g = color[15:8];
        b = color[7:0];
        if (fmt == Format666) begin
            return {r & Mask666, g & Mask666, b & Mask666};
        end
        return {8'h00, r[7:3], g[7:5], g[4:2], b[7:3]};
    endfunction

endpackage

### sv/lwf_cfg.sv
// APB register block: panel size and pixel format.
module lwf_cfg import lwf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                RegPanelWidth:  cfg_next.panel_width  = pwdata[CfgW-1:0];
                RegPanelHeight: cfg_next.panel_height = pwdata[CfgW-1:0];
                RegPixelFormat: cfg_next.pixel_format = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegPanelWidth:  prdata = DataW'(cfg_reg.panel_width);
            RegPanelHeight: prdata = DataW'(cfg_reg.panel_height);
            RegPixelFormat: prdata = DataW'(cfg_reg.pixel_format);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width  <= ResetPanelWidth;
            cfg_reg.panel_height <= ResetPanelHeight;
            cfg_reg.pixel_format <= ResetPixelFormat;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/lwf_front.sv
// Request front end: colour store, pixel culling, corner ordering and clamping, run size.
module lwf_front import lwf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic signed [CoordW-1:0] s_x_first,
    input  logic signed [CoordW-1:0] s_y_first,
    input  logic signed [CoordW-1:0] s_x_second,
    input  logic signed [CoordW-1:0] s_y_second,
    input  logic [ColorW-1:0]        s_rgb_color,
    input  logic                     q_full,
    output logic                     push,
    output draw_cmd_t                push_data
);

    logic [ColorW-1:0] color_reg;
    logic [ColorW-1:0] color_next;

    // Stage A: raw corners and packed pixel
    logic                     a_valid_reg;
    logic                     a_valid_next;
    logic signed [CoordW-1:0] xa_reg;
    logic signed [CoordW-1:0] ya_reg;
    logic signed [CoordW-1:0] xb_reg;
    logic signed [CoordW-1:0] yb_reg;
    logic [ColorW-1:0]        a_pattern_reg;

    // Stage B: ordered, clamped window
    logic              b_valid_reg;
    logic              b_valid_next;
    logic [SideW-1:0]  bx_lo_reg;
    logic [SideW-1:0]  bx_hi_reg;
    logic [SideW-1:0]  by_lo_reg;
    logic [SideW-1:0]  by_hi_reg;
    logic [ColorW-1:0] b_pattern_reg;

    logic [SideW-1:0]   w_eff;
    logic [SideW-1:0]   h_eff;
    logic               on_screen;
    logic               draw_ok;
    logic               accept;
    logic               a_go;
    logic               b_go;
    logic [SideW-1:0]   x_lo_c;
    logic [SideW-1:0]   x_hi_c;
    logic [SideW-1:0]   y_lo_c;
    logic [SideW-1:0]   y_hi_c;
    logic [SideW-1:0]   dx;
    logic [SideW-1:0]   dy;
    logic [2*SideW-1:0] area;

    assign w_eff = eff_side(cfg.panel_width);
    assign h_eff = eff_side(cfg.panel_height);

    assign on_screen = !s_x_first[CoordW-1] && !s_y_first[CoordW-1]
                    && ({1'b0, s_x_first[CoordW-2:0]} < CoordW'(w_eff))
                    && ({1'b0, s_y_first[CoordW-2:0]} < CoordW'(h_eff));
    assign draw_ok = (s_op == OP_FILL) || ((s_op == OP_PIXEL) && on_screen);

    assign b_go    = b_valid_reg && !q_full;
    assign a_go    = a_valid_reg && (!b_valid_reg || b_go);
    assign s_ready = !a_valid_reg || !b_valid_reg || b_go;
    assign accept  = s_valid && s_ready;

    always_comb begin
        color_next   = color_reg;
        a_valid_next = a_valid_reg && !a_go;
        b_valid_next = b_valid_reg && !b_go;
        if (accept && (s_op == OP_SET_COLOR)) begin
            color_next = s_rgb_color;
        end
        if (accept && draw_ok) begin
            a_valid_next = 1'b1;
        end
        if (a_go) begin
            b_valid_next = 1'b1;
        end
    end

    // Order the corners, then clamp each to the panel
    always_comb begin
        if (xa_reg > xb_reg) begin
            x_lo_c = clamp_coord(xb_reg, w_eff);
            x_hi_c = clamp_coord(xa_reg, w_eff);
        end else begin
            x_lo_c = clamp_coord(xa_reg, w_eff);
            x_hi_c = clamp_coord(xb_reg, w_eff);
        end
        if (ya_reg > yb_reg) begin
            y_lo_c = clamp_coord(yb_reg, h_eff);
            y_hi_c = clamp_coord(ya_reg, h_eff);
        end else begin
            y_lo_c = clamp_coord(ya_reg, h_eff);
            y_hi_c = clamp_coord(yb_reg, h_eff);
        end
    end

    assign dx   = bx_hi_reg - bx_lo_reg + 1'b1;
    assign dy   = by_hi_reg - by_lo_reg + 1'b1;
    assign area = dx * dy;

    always_comb begin
        push              = b_go;
        push_data.x_lo    = bx_lo_reg;
        push_data.x_hi    = bx_hi_reg;
        push_data.y_lo    = by_lo_reg;
        push_data.y_hi    = by_hi_reg;
        push_data.pattern = b_pattern_reg;
        if (32'(area) > 32'(RunMax)) begin
            push_data.run = RunMax;
        end else begin
            push_data.run = RunW'(area);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            color_reg   <= color_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // A single pixel is a one-by-one window
    always_ff @(posedge aclk) begin
        if (accept && draw_ok) begin
            xa_reg        <= s_x_first;
            ya_reg        <= s_y_first;
            xb_reg        <= (s_op == OP_FILL) ? s_x_second : s_x_first;
            yb_reg        <= (s_op == OP_FILL) ? s_y_second : s_y_first;
            a_pattern_reg <= pack_pixel(color_reg, cfg.pixel_format);
        end
        if (a_go) begin
            bx_lo_reg     <= x_lo_c;
            bx_hi_reg     <= x_hi_c;
            by_lo_reg     <= y_lo_c;
            by_hi_reg     <= y_hi_c;
            b_pattern_reg <= a_pattern_reg;
        end
    end

endmodule

### sv/lwf_queue.sv
// Short queue of draw windows between front end and byte sequencer.
module lwf_queue import lwf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  draw_cmd_t        push_data,
    input  logic             pop,
    output draw_cmd_t        pop_data,
    output logic             full,
    output logic             empty,
    output logic [QCntW-1:0] count
);

    draw_cmd_t        entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;

    assign full     = count_reg == QCntW'(QDepth);
    assign empty    = count_reg == '0;
    assign count    = count_reg;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCntW'(push) - QCntW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/lwf_back.sv
// Byte sequencer: window tracking and the per-draw result beats.
module lwf_back import lwf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  draw_cmd_t         q_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_kind,
    output logic [7:0]        m_byte_value,
    output logic [ColorW-1:0] m_pixel_pattern,
    output logic [RunW-1:0]   m_run_length,
    output logic              m_last
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CS_LOW   = 9'b000000010,
        ST_COL_CMD  = 9'b000000100,
        ST_COL_DATA = 9'b000001000,
        ST_ROW_CMD  = 9'b000010000,
        ST_ROW_DATA = 9'b000100000,
        ST_RAM      = 9'b001000000,
        ST_RUN      = 9'b010000000,
        ST_CS_HIGH  = 9'b100000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [1:0]        byte_cnt_reg;
    logic [1:0]        byte_cnt_next;
    draw_cmd_t         cmd_reg;
    draw_cmd_t         cmd_next;
    logic [CoordW-1:0] win_col_start_reg;
    logic [CoordW-1:0] win_col_start_next;
    logic [CoordW-1:0] win_col_end_reg;
    logic [CoordW-1:0] win_col_end_next;
    logic [CoordW-1:0] win_row_start_reg;
    logic [CoordW-1:0] win_row_start_next;
    logic [CoordW-1:0] win_row_end_reg;
    logic [CoordW-1:0] win_row_end_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    kind_t             m_kind_reg;
    kind_t             m_kind_next;
    logic [7:0]        m_byte_reg;
    logic [7:0]        m_byte_next;
    logic [ColorW-1:0] m_pattern_reg;
    logic [ColorW-1:0] m_pattern_next;
    logic [RunW-1:0]   m_run_reg;
    logic [RunW-1:0]   m_run_next;
    logic              m_last_reg;
    logic              m_last_next;

    logic                out_free;
    logic                col_diff;
    logic                row_diff;
    logic [2*CoordW-1:0] col_word;
    logic [2*CoordW-1:0] row_word;
    logic [1:0]          byte_sel;

    assign out_free = !m_valid_reg || m_ready;
    assign col_word = {CoordW'(cmd_reg.x_lo), CoordW'(cmd_reg.x_hi)};
    assign row_word = {CoordW'(cmd_reg.y_lo), CoordW'(cmd_reg.y_hi)};
    assign col_diff = (col_word != {win_col_start_reg, win_col_end_reg});
    assign row_diff = (row_word != {win_row_start_reg, win_row_end_reg});
    // Start high byte goes first
    assign byte_sel = ~byte_cnt_reg;

    always_comb begin
        state_next         = state_reg;
        byte_cnt_next      = byte_cnt_reg;
        cmd_next           = cmd_reg;
        win_col_start_next = win_col_start_reg;
        win_col_end_next   = win_col_end_reg;
        win_row_start_next = win_row_start_reg;
        win_row_end_next   = win_row_end_reg;
        pop                = 1'b0;
        m_valid_next       = m_valid_reg && !m_ready;
        m_kind_next        = m_kind_reg;
        m_byte_next        = m_byte_reg;
        m_pattern_next     = m_pattern_reg;
        m_run_next         = m_run_reg;
        m_last_next        = m_last_reg;

        if ((state_reg != ST_IDLE) && out_free) begin
            m_valid_next   = 1'b1;
            m_byte_next    = '0;
            m_pattern_next = '0;
            m_run_next     = '0;
            m_last_next    = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    cmd_next   = q_data;
                    state_next = ST_CS_LOW;
                end
            end
            ST_CS_LOW: begin
                if (out_free) begin
                    m_kind_next = KIND_CS_LOW;
                    state_next  = col_diff ? ST_COL_CMD : (row_diff ? ST_ROW_CMD : ST_RAM);
                end
            end
            ST_COL_CMD: begin
                if (out_free) begin
                    m_kind_next        = KIND_CMD;
                    m_byte_next        = CmdColumnSet;
                    win_col_start_next = col_word[2*CoordW-1:CoordW];
                    win_col_end_next   = col_word[CoordW-1:0];
                    byte_cnt_next      = '0;
                    state_next         = ST_COL_DATA;
                end
            end
            ST_COL_DATA: begin
                if (out_free) begin
                    m_kind_next   = KIND_DATA;
                    m_byte_next   = col_word[{byte_sel, 3'b000} +: 8];
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == '1) begin
                        state_next = row_diff ? ST_ROW_CMD : ST_RAM;
                    end
                end
            end
            ST_ROW_CMD: begin
                if (out_free) begin
                    m_kind_next        = KIND_CMD;
                    m_byte_next        = CmdRowSet;
                    win_row_start_next = row_word[2*CoordW-1:CoordW];
                    win_row_end_next   = row_word[CoordW-1:0];
                    byte_cnt_next      = '0;
                    state_next         = ST_ROW_DATA;
                end
            end
            ST_ROW_DATA: begin
                if (out_free) begin
                    m_kind_next   = KIND_DATA;
                    m_byte_next   = row_word[{byte_sel, 3'b000} +: 8];
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    if (byte_cnt_reg == '1) begin
                        state_next = ST_RAM;
                    end
                end
            end
            ST_RAM: begin
                if (out_free) begin
                    m_kind_next = KIND_CMD;
                    m_byte_next = CmdRamWrite;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    m_kind_next    = KIND_RUN;
                    m_pattern_next = cmd_reg.pattern;
                    m_run_next     = cmd_reg.run;
                    state_next     = ST_CS_HIGH;
                end
            end
            ST_CS_HIGH: begin
                if (out_free) begin
                    m_kind_next = KIND_CS_HIGH;
                    m_last_next = 1'b1;
                    // Chain straight into the next draw when one is waiting
                    if (!q_empty) begin
                        pop        = 1'b1;
                        cmd_next   = q_data;
                        state_next = ST_CS_LOW;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            byte_cnt_reg      <= '0;
            win_col_start_reg <= '1;
            win_col_end_reg   <= '1;
            win_row_start_reg <= '1;
            win_row_end_reg   <= '1;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            byte_cnt_reg      <= byte_cnt_next;
            win_col_start_reg <= win_col_start_next;
            win_col_end_reg   <= win_col_end_next;
            win_row_start_reg <= win_row_start_next;
            win_row_end_reg   <= win_row_end_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        m_kind_reg    <= m_kind_next;
        m_byte_reg    <= m_byte_next;
        m_pattern_reg <= m_pattern_next;
        m_run_reg     <= m_run_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_byte_value    = m_byte_reg;
    assign m_pixel_pattern = m_pattern_reg;
    assign m_run_length    = m_run_reg;
    assign m_last          = m_last_reg;

endmodule

### sv/lcd_window_fill_streamer_core.sv
// Draw requests in, serial TFT panel beats out: chip select, window commands, pixel run.
// The input side takes one request per cycle unless the queue backs it up: set-colour
// requests and off-screen pixels finish there and produce no beats. Each drawn pixel
// or fill turns into 4 beats (window unchanged), 9 beats (one of column or row window
// changed) or 14 beats (both changed); the byte sequencer issues one beat per cycle
// while m_ready is high, so that sequencer sets the sustained rate. A request passes
// through front-end stages A and B and a four-entry queue on its way to the sequencer;
// the queue keeps the input side accepting while beats of earlier draws are still
// going out.
`include "lcd_window_fill_streamer_core_macros.svh"

module lcd_window_fill_streamer_core import lwf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [AddrW-1:0]         paddr,
    input  logic [DataW-1:0]         pwdata,
    output logic [DataW-1:0]         prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic signed [CoordW-1:0] s_x_first,
    input  logic signed [CoordW-1:0] s_y_first,
    input  logic signed [CoordW-1:0] s_x_second,
    input  logic signed [CoordW-1:0] s_y_second,
    input  logic [ColorW-1:0]        s_rgb_color,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_kind,
    output logic [7:0]               m_byte_value,
    output logic [ColorW-1:0]        m_pixel_pattern,
    output logic [RunW-1:0]          m_run_length,
    output logic                     m_last
);

    cfg_t             cfg;
    logic             push;
    draw_cmd_t        push_data;
    logic             pop;
    draw_cmd_t        pop_data;
    logic             q_full;
    logic             q_empty;
    logic [QCntW-1:0] q_count;

    lwf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lwf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_x_first   (s_x_first),
        .s_y_first   (s_y_first),
        .s_x_second  (s_x_second),
        .s_y_second  (s_y_second),
        .s_rgb_color (s_rgb_color),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    lwf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    lwf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (pop_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_byte_value    (m_byte_value),
        .m_pixel_pattern (m_pixel_pattern),
        .m_run_length    (m_run_length),
        .m_last          (m_last)
    );

    // Queue never overfills or pops when empty
    `LWF_ASSERT_IMP(a_queue_bound, aclk, aresetn, 1'b1, q_count <= QCntW'(QDepth))
    // Only the deselect beat closes a draw
    `LWF_ASSERT_IMP(a_last_is_cs_high, aclk, aresetn, m_valid && m_last, m_kind == KIND_CS_HIGH)
    // A pixel run always covers at least one pixel
    `LWF_ASSERT_IMP(a_run_nonzero, aclk, aresetn, m_valid && (m_kind == KIND_RUN),
        m_run_length != '0)
    // The deselect beat follows a taken run beat at once
    `LWF_ASSERT_NXT(a_run_then_cs_high, aclk, aresetn,
        m_valid && m_ready && (m_kind == KIND_RUN), m_valid && (m_kind == KIND_CS_HIGH))

endmodule
